[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[design/srn_pkg.sv]
// Package: shared constants and types for the scaled reciprocal norm block.
package srn_pkg;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int SUM_W          = 64;
	localparam int RES_W          = 32;

	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_SHIFT = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQR,
		BK_ROOT
	} bk_state_t;

	typedef struct packed {
		logic        zero_den;
		logic        neg;
		logic        last;
	} srn_flags_t;
endpackage

[design/srn_front.sv]
// Front part: takes an eigenvalue, forms the denominator and its magnitude, classifies it.
module srn_front import srn_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] eigen_value,
	input  logic                  is_last,
	input  logic [DATA_WIDTH-1:0] alpha,
	input  logic [DATA_WIDTH-1:0] shift,
	output logic                  q_valid,
	input  logic                  q_ready,
	output logic [DATA_WIDTH:0]   q_dmag,
	output logic [DATA_WIDTH-1:0] q_amag,
	output srn_flags_t            q_flags
);
	// two-entry queue
	logic [1:0]           vld_q;
	logic [DATA_WIDTH:0]  dmag_q [2];
	logic [DATA_WIDTH-1:0] amag_q [2];
	srn_flags_t           fl_q [2];
	logic                 wr_q, rd_q;

	logic signed [DATA_WIDTH:0] den;
	logic [DATA_WIDTH:0]        dmag;
	logic [DATA_WIDTH-1:0]      amag;
	srn_flags_t                 fl;
	logic                       push, pop;

	always_comb begin
		den = {eigen_value[DATA_WIDTH-1], eigen_value} + {shift[DATA_WIDTH-1], shift};
		dmag = den[DATA_WIDTH] ? -den : den;
		amag = alpha[DATA_WIDTH-1] ? -alpha : alpha;
		fl.zero_den = (den == '0);
		fl.neg = (alpha != '0) && (alpha[DATA_WIDTH-1] != den[DATA_WIDTH]);
		fl.last = is_last;
	end

	assign in_ready = !vld_q[wr_q];
	assign push = in_valid && in_ready;
	assign q_valid = vld_q[rd_q];
	assign pop = q_valid && q_ready;
	assign q_dmag = dmag_q[rd_q];
	assign q_amag = amag_q[rd_q];
	assign q_flags = fl_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) begin
				vld_q[wr_q] <= 1'b1;
				wr_q <= !wr_q;
			end
			if (pop) begin
				vld_q[rd_q] <= 1'b0;
				rd_q <= !rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			dmag_q[wr_q] <= dmag;
			amag_q[wr_q] <= amag;
			fl_q[wr_q] <= fl;
		end
	end
endmodule

[design/srn_back.sv]
// Back part: serial divide, square, accumulate and serial square root.
module srn_back import srn_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [DATA_WIDTH:0]   q_dmag,
	input  logic [DATA_WIDTH-1:0] q_amag,
	input  srn_flags_t            q_flags,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RES_W-1:0]      norm_value,
	output logic                  saturated,
	output logic                  divide_by_zero
);
	localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int RCNT  = SUM_W / 2;
	localparam int RCNT_W = $clog2(RCNT + 1);
	localparam logic [NUM_W-1:0] LIM_POS = NUM_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(64'd1 << (DATA_WIDTH - 1));

	bk_state_t state_q, state_d;
	logic [NUM_W-1:0]      num_q;   // dividend shifts out, quotient shifts in
	logic [DATA_WIDTH+1:0] rem_q;
	logic [DATA_WIDTH:0]   dmag_q;
	srn_flags_t            fl_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic                  sat_q, zdv_q;
	logic [SUM_W-1:0]      rn_q;
	logic [RES_W:0]        root_q;
	logic [SUM_W/2+1:0]    rrem_q;
	logic [RCNT_W-1:0]     rcnt_q;
	logic                  ov_q;
	logic [RES_W-1:0]      res_q;
	logic                  res_sat_q, res_zdv_q;

	logic [DATA_WIDTH+1:0] rem_sh, rem_sub;
	logic [NUM_W-1:0]      lim, qmag;
	logic                  qsat;
	logic [2*DATA_WIDTH-1:0] sq;
	logic [SUM_W:0]        nsum;
	logic [SUM_W/2+1:0]    rr_sh, rr_try;

	always_comb begin
		rem_sh = {rem_q[DATA_WIDTH:0], num_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, dmag_q};
		lim = fl_q.neg ? LIM_NEG : LIM_POS;
		qsat = !fl_q.zero_den && (num_q > lim);
		qmag = fl_q.zero_den ? LIM_POS : (qsat ? lim : num_q);
		sq = qmag[DATA_WIDTH-1:0] * qmag[DATA_WIDTH-1:0];
		nsum = {1'b0, sum_q} + {{(SUM_W + 1 - 2 * DATA_WIDTH){1'b0}}, sq};
		rr_sh = {rrem_q[SUM_W/2-1:0], rn_q[SUM_W-1:SUM_W-2]};
		// partial root stays below 2^31 until the last step
		rr_try = rr_sh - {root_q[RES_W-1:0], 2'b01};
	end

	assign q_ready = (state_q == BK_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign norm_value = res_q;
	assign saturated = res_sat_q;
	assign divide_by_zero = res_zdv_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (q_valid && q_ready) state_d = BK_DIV;
			BK_DIV:  if (cnt_q == CNT_W'(NUM_W - 1)) state_d = BK_SQR;
			BK_SQR:  state_d = fl_q.last ? BK_ROOT : BK_IDLE;
			BK_ROOT: if (rcnt_q == RCNT_W'(RCNT - 1)) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			sum_q <= '0;
			sat_q <= 1'b0;
			zdv_q <= 1'b0;
			ov_q <= 1'b0;
			cnt_q <= '0;
			rcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) ov_q <= 1'b0;
			case (state_q)
				BK_IDLE: cnt_q <= '0;
				BK_DIV:  cnt_q <= cnt_q + 1'b1;
				BK_SQR: begin
					rcnt_q <= '0;
					sum_q <= nsum[SUM_W] ? '1 : nsum[SUM_W-1:0];
					if (qsat || nsum[SUM_W]) sat_q <= 1'b1;
					if (fl_q.zero_den) zdv_q <= 1'b1;
				end
				BK_ROOT: begin
					rcnt_q <= rcnt_q + 1'b1;
					if (rcnt_q == RCNT_W'(RCNT - 1)) begin
						ov_q <= 1'b1;
						sum_q <= '0;
						sat_q <= 1'b0;
						zdv_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				num_q <= {q_amag, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				dmag_q <= q_dmag;
				fl_q <= q_flags;
			end
			BK_DIV: begin
				if (rem_sub[DATA_WIDTH+1]) begin
					rem_q <= rem_sh;
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end else begin
					rem_q <= rem_sub;
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end
			end
			BK_SQR: begin
				rn_q <= nsum[SUM_W] ? '1 : nsum[SUM_W-1:0];
				root_q <= '0;
				rrem_q <= '0;
			end
			BK_ROOT: begin
				rn_q <= {rn_q[SUM_W-3:0], 2'b00};
				if (rr_try[SUM_W/2+1]) begin
					rrem_q <= rr_sh;
					root_q <= {root_q[RES_W-1:0], 1'b0};
				end else begin
					rrem_q <= rr_try;
					root_q <= {root_q[RES_W-1:0], 1'b1};
				end
				if (rcnt_q == RCNT_W'(RCNT - 1)) begin
					res_q <= rr_try[SUM_W/2+1] ? {root_q[RES_W-2:0], 1'b0}
						: {root_q[RES_W-2:0], 1'b1};
					res_sat_q <= sat_q;
					res_zdv_q <= zdv_q;
				end
			end
			default: ;
		endcase
	end
endmodule

[design/scaled_reciprocal_norm_top.sv]
// Top level: scaled reciprocal norm of a shifted eigenvalue stream.
// channel | dir | tdata                         | tuser/tlast
// s_axis  | in  | [31:0] eigen_value            | tlast = is_last
// m_axis  | out | [31:0] norm_value             | tuser[0] saturated, [1] divide_by_zero
// cfg     | in  | cfg_data -> reg cfg_index     | index 0 scale_alpha, 1 diagonal_shift
// Each item runs through the serial divider and then the squaring step;
// a last item then also runs the bit-serial square root.
// The two-entry front queue keeps accepting while the divider works, until both entries are full.
// A pending result stalls further items until m_axis_tready takes it.
// arst_n clears control, the sum, flags and sets the registers to their reset values.
module scaled_reciprocal_norm_top import srn_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] eigen_value
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] norm_value
	output logic [1:0]  m_axis_tuser,   // [0] saturated, [1] divide_by_zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] alpha_q, shift_q;
	logic                  qv, qr;
	logic [DATA_WIDTH:0]   qd;
	logic [DATA_WIDTH-1:0] qa;
	srn_flags_t            qf;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 32'd65536;
			shift_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCALE: alpha_q <= cfg_data;
				REG_SHIFT: shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	srn_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.eigen_value(s_axis_tdata[DATA_WIDTH-1:0]), .is_last(s_axis_tlast),
		.alpha(alpha_q[DATA_WIDTH-1:0]), .shift(shift_q[DATA_WIDTH-1:0]),
		.q_valid(qv), .q_ready(qr), .q_dmag(qd), .q_amag(qa), .q_flags(qf)
	);

	srn_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.q_valid(qv), .q_ready(qr), .q_dmag(qd), .q_amag(qa), .q_flags(qf),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.norm_value(m_axis_tdata), .saturated(m_axis_tuser[0]),
		.divide_by_zero(m_axis_tuser[1])
	);
endmodule

[design/srn_checker.sv]
// Checker: port-level properties of the scaled reciprocal norm block, with its bind.
`include "assert_macros.svh"
module srn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	logic        out_stall, out_take;
	logic [33:0] out_word;
	logic [2:0]  hs_bits;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_take  = m_axis_tvalid && m_axis_tready;
	assign out_word  = {m_axis_tuser, m_axis_tdata};
	assign hs_bits   = {s_axis_tvalid, s_axis_tready, m_axis_tvalid};

	`CHK_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word), "result moved")
	`CHK_NEXT(a_one_take, clk, arst_n, out_take, !m_axis_tvalid, "result repeated")
	`CHK_IMPL(a_hs_known, clk, arst_n, 1'b1, !$isunknown(hs_bits), "handshake unknown")
	`CHK_IMPL(a_out_known, clk, arst_n, m_axis_tvalid, !$isunknown(out_word), "result unknown")
endmodule

bind scaled_reciprocal_norm_top srn_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
